>>> rtl/page_replacement_policy_engine_core_defines.svh
// assertion macros for the page replacement engine
// used by the checker module; no other dependencies
`ifndef PAGE_REPLACEMENT_POLICY_ENGINE_CORE_DEFINES_SVH
`define PAGE_REPLACEMENT_POLICY_ENGINE_CORE_DEFINES_SVH
// implication checked every clock outside reset
`define PRP_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define PRP_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

>>> rtl/prpe_pkg.sv
// shared types and constants for the page replacement engine
// no dependencies
package prpe_pkg;
  localparam logic [2:0] POL_FIFO  = 3'd0;
  localparam logic [2:0] POL_LFU   = 3'd1;
  localparam logic [2:0] POL_LRU   = 3'd2;
  localparam logic [2:0] POL_CLOCK = 3'd3;
  localparam logic [2:0] POL_AGING = 3'd4;
  localparam logic [3:0] RANK_MAX  = 4'd15;
  localparam logic [7:0] AGE_MSB   = 8'h80;
  localparam logic [15:0] META_MAX = 16'hFFFF;

  // configuration register byte addresses
  localparam logic [2:0] REG_POLICY = 3'd0;
  localparam logic [2:0] REG_FRAMES = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_SWEEP, ST_UPDATE, ST_OUT
  } state_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic       lookup;  // compare against request page
    logic       upd;     // apply update for accessed frame
    logic       load;    // accessed frame takes a new page
    logic       clr_ref; // clear reference bit of selected frame
    logic [2:0] pol;
  } cell_cmd_t;
endpackage

>>> rtl/prpe_cell.sv
// one frame cell: page, valid, meta and rank
// depends on prpe_pkg
module prpe_cell import prpe_pkg::*; #(
  parameter int PAGE_BITS = 16,
  parameter int IDX_BITS  = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 active,
  input  logic [IDX_BITS-1:0]  my_idx,
  input  cell_cmd_t            cmd,
  input  logic [PAGE_BITS-1:0] req_page,
  input  logic [IDX_BITS-1:0]  sel_idx,
  input  logic [3:0]           sel_rank,
  output logic                 match,
  output logic                 valid,
  output logic [PAGE_BITS-1:0] page,
  output logic [15:0]          meta,
  output logic [3:0]           rank
);
  logic [PAGE_BITS-1:0] page_r;
  logic valid_r;
  logic [15:0] meta_r, meta_nxt;
  logic [3:0] rank_r, rank_nxt;
  logic me;

  assign me = (sel_idx == my_idx);
  assign match = active && valid_r && (page_r == req_page);
  assign valid = valid_r;
  assign page = page_r;
  assign meta = meta_r;
  assign rank = rank_r;

  always_comb begin
    meta_nxt = meta_r;
    rank_nxt = rank_r;
    if (cmd.clr_ref && me) meta_nxt = '0;
    if (cmd.upd && active) begin
      unique case (cmd.pol)
        POL_LFU: if (me) meta_nxt = cmd.load ? 16'd1 :
                   ((meta_r < META_MAX) ? meta_r + 16'd1 : meta_r);
        POL_LRU: begin
          if (me) begin
            rank_nxt = '0;
            if (cmd.load) meta_nxt = '0;
          end else if (valid_r && rank_r < sel_rank && rank_r < RANK_MAX)
            rank_nxt = rank_r + 4'd1;
        end
        POL_CLOCK: if (me) meta_nxt = cmd.load ? 16'd0 : 16'd1;
        POL_AGING: begin
          if (me) meta_nxt = cmd.load ? {8'd0, AGE_MSB} :
                   {8'd0, AGE_MSB | (meta_r[7:0] >> 1)};
          else if (valid_r) meta_nxt = {8'd0, 1'b0, meta_r[7:1]};
        end
        default: if (me && cmd.load) meta_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      meta_r  <= '0;
      rank_r  <= '0;
    end else begin
      meta_r <= meta_nxt;
      rank_r <= rank_nxt;
      if (cmd.upd && cmd.load && active && me) valid_r <= 1'b1;
    end
    if (cmd.upd && cmd.load && active && me) page_r <= req_page;
  end
endmodule

>>> rtl/page_replacement_policy_engine_core.sv
// top level of the page replacement engine: control, scan and config port
// depends on prpe_pkg, prpe_cell
//
//  channel | dir | ports
//  in      | in  | in_valid, in_ready, in_page
//  out     | out | out_valid, out_ready, out_hit .. out_replacement_count
//  cfg     | in  | psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// a hit or a fill passes through the lookup, update and output states after the request
// is taken, and the engine returns to idle before it takes the next request; a
// replacement adds a victim scan of one frame per cycle from the hand, while clock
// sweeps instead, clearing set reference bits until a clear one is met
// reset clears valid, meta and rank at once; a waiting result holds while
// out_ready is low and no new request is taken until it leaves
module page_replacement_policy_engine_core import prpe_pkg::*; #(
  parameter int MAX_FRAMES = 16,
  parameter int PAGE_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PAGE_BITS-1:0] in_page,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_hit,
  output logic                 out_filled_empty,
  output logic                 out_replaced,
  output logic [3:0]           out_frame,
  output logic [15:0]          out_evicted_page,
  output logic [31:0]          out_replacement_count,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  localparam int IB = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CB = IB + 2; // scan counter up to 2n

  logic [2:0] policy_r;
  logic [4:0] frames_r;
  state_t state_r, state_nxt;
  logic [PAGE_BITS-1:0] req_r;
  logic [IB-1:0] hand_r, hand_nxt, f_r, f_nxt, idx_r, idx_nxt, best_r, best_nxt;
  logic [CB-1:0] cnt_r, cnt_nxt;
  logic [31:0] total_r, total_nxt;
  logic hit_r, hit_nxt, fill_r, fill_nxt, repl_r, repl_nxt;
  logic [15:0] evict_r, evict_nxt;
  logic [2:0] pol;
  logic [IB:0] n;
  cell_cmd_t cmd;
  logic [MAX_FRAMES-1:0] act, mat, vld;
  logic [PAGE_BITS-1:0] pg [MAX_FRAMES];
  logic [15:0] mt [MAX_FRAMES];
  logic [3:0] rk [MAX_FRAMES];
  logic found, empty;
  logic [IB-1:0] mat_idx, emp_idx, h, idx_inc;
  logic [IB-1:0] sel_idx;
  logic [3:0] sel_rank;

  assign pready = 1'b1;
  assign pol = (policy_r > POL_AGING) ? POL_FIFO : policy_r;
  always_comb begin
    if (frames_r == 5'd0) n = (IB+1)'(1);
    else if (32'(frames_r) > MAX_FRAMES) n = (IB+1)'(MAX_FRAMES);
    else n = (IB+1)'(frames_r);
  end
  assign h = ({1'b0, hand_r} < n) ? hand_r : '0;
  assign idx_inc = ({1'b0, idx_r} + 1'b1 >= n) ? '0 : idx_r + 1'b1;

  // the sweep clears the frame under the scan index; a load ages against rank 15
  assign sel_idx = cmd.clr_ref ? idx_r : f_r;
  assign sel_rank = cmd.load ? RANK_MAX : rk[f_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POL_FIFO;
      frames_r <= 5'd5;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        REG_POLICY: policy_r <= pwdata[2:0];
        REG_FRAMES: frames_r <= pwdata[4:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (paddr)
      REG_POLICY: prdata = {29'd0, policy_r};
      REG_FRAMES: prdata = {27'd0, frames_r};
      default: prdata = '0;
    endcase
  end

  // the row of frame cells
  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    assign act[i] = (i < n);
    prpe_cell #(.PAGE_BITS(PAGE_BITS), .IDX_BITS(IB)) u_cell (
      .clk(clk), .rst_n(rst_n), .active(act[i]), .my_idx(IB'(i)), .cmd(cmd),
      .req_page(req_r), .sel_idx(sel_idx), .sel_rank(sel_rank),
      .match(mat[i]), .valid(vld[i]), .page(pg[i]), .meta(mt[i]), .rank(rk[i])
    );
  end

  // first match and first empty, lowest index wins
  always_comb begin
    found = 1'b0; empty = 1'b0; mat_idx = '0; emp_idx = '0;
    for (int i = MAX_FRAMES-1; i >= 0; i--) begin
      if (mat[i]) begin found = 1'b1; mat_idx = IB'(i); end
      if (act[i] && !vld[i]) begin empty = 1'b1; emp_idx = IB'(i); end
    end
  end

  always_comb begin
    state_nxt = state_r;
    hand_nxt = hand_r; f_nxt = f_r; idx_nxt = idx_r; best_nxt = best_r;
    cnt_nxt = cnt_r; total_nxt = total_r;
    hit_nxt = hit_r; fill_nxt = fill_r; repl_nxt = repl_r; evict_nxt = evict_r;
    cmd = '{lookup: 1'b0, upd: 1'b0, load: 1'b0, clr_ref: 1'b0, pol: pol};
    in_ready = (state_r == ST_IDLE);
    out_valid = (state_r == ST_OUT);
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_SCAN;
      ST_SCAN: begin
        // first scan cycle: lookup decision
        if (cnt_r == '0) begin
          hit_nxt = found; fill_nxt = !found && empty; repl_nxt = !found && !empty;
          evict_nxt = '0;
          if (found) begin
            f_nxt = mat_idx; hand_nxt = h; state_nxt = ST_UPDATE;
          end else if (empty) begin
            f_nxt = emp_idx; state_nxt = ST_UPDATE;
          end else if (pol == POL_CLOCK) begin
            idx_nxt = h; state_nxt = ST_SWEEP;
          end else begin
            best_nxt = h; idx_nxt = h; cnt_nxt = CB'(1);
            if ((pol == POL_FIFO) || n == (IB+1)'(1)) begin
              f_nxt = h; state_nxt = ST_UPDATE; cnt_nxt = '0;
            end else idx_nxt = ({1'b0, h} + 1'b1 >= n) ? '0 : h + 1'b1;
          end
        end else begin
          // one frame per cycle from the hand
          if ((pol == POL_LFU && mt[idx_r] < mt[best_r]) ||
              (pol == POL_LRU && rk[idx_r] > rk[best_r]) ||
              (pol == POL_AGING && mt[idx_r][7:0] < mt[best_r][7:0]))
            best_nxt = idx_r;
          idx_nxt = idx_inc;
          cnt_nxt = cnt_r + 1'b1;
          if ({1'b0, cnt_r} + 1'b1 >= {1'b0, n}) begin
            f_nxt = ((pol == POL_LFU && mt[idx_r] < mt[best_r]) ||
                     (pol == POL_LRU && rk[idx_r] > rk[best_r]) ||
                     (pol == POL_AGING && mt[idx_r][7:0] < mt[best_r][7:0]))
                    ? idx_r : best_r;
            cnt_nxt = '0;
            state_nxt = ST_UPDATE;
          end
        end
      end
      ST_SWEEP: begin
        // clock: clear set bits until a clear one is met or the counter reaches 2n
        if (!mt[idx_r][0] || cnt_r >= CB'(2*n)) begin
          f_nxt = mt[idx_r][0] ? h : idx_r;
          cnt_nxt = '0; state_nxt = ST_UPDATE;
        end else begin
          f_nxt = idx_r; cmd.clr_ref = 1'b1;
          idx_nxt = idx_inc; cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_UPDATE: begin
        cmd.upd = 1'b1; cmd.load = !hit_r;
        if (repl_r) begin
          evict_nxt = 16'(pg[f_r]);
          if (total_r != 32'hFFFF_FFFF) total_nxt = total_r + 32'd1;
        end
        if (!hit_r) hand_nxt = ({1'b0, f_r} + 1'b1 >= n) ? '0 : f_r + 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      hand_r <= '0;
      total_r <= '0;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      hand_r <= hand_nxt;
      total_r <= total_nxt;
      cnt_r <= cnt_nxt;
    end
    if (in_valid && in_ready) req_r <= in_page;
    f_r <= f_nxt; idx_r <= idx_nxt; best_r <= best_nxt;
    hit_r <= hit_nxt; fill_r <= fill_nxt; repl_r <= repl_nxt; evict_r <= evict_nxt;
  end

  assign out_hit = hit_r;
  assign out_filled_empty = fill_r;
  assign out_replaced = repl_r;
  assign out_frame = 4'(f_r);
  assign out_evicted_page = evict_r;
  assign out_replacement_count = total_r;
endmodule

>>> rtl/prpe_checker.sv
// port-level checks for the page replacement engine
// depends on the defines header; bound to the top level
`include "page_replacement_policy_engine_core_defines.svh"
module prpe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_hit,
  input logic        out_filled_empty,
  input logic        out_replaced,
  input logic [15:0] out_evicted_page,
  input logic [31:0] out_replacement_count
);
  `PRP_ASSERT_IMP(a_one_hot, out_valid, $onehot({out_hit, out_filled_empty, out_replaced}))
  `PRP_ASSERT_IMP(a_evict_zero, out_valid && !out_replaced, out_evicted_page == 16'd0)
  `PRP_ASSERT_IMP(a_no_overlap, out_valid, !in_ready)
  `PRP_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_replacement_count))
endmodule

bind page_replacement_policy_engine_core prpe_checker u_prpe_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_hit(out_hit),
  .out_filled_empty(out_filled_empty), .out_replaced(out_replaced),
  .out_evicted_page(out_evicted_page), .out_replacement_count(out_replacement_count)
);
